/* rtl/core/rpmslb_pkg.sv */
// ----------------------------------------------------------------------------
// rpmslb_pkg
// Shared widths, constants, register indexes and types for the shift light bar.
// ----------------------------------------------------------------------------
package rpmslb_pkg;

	// Bar geometry.
	localparam int LED_COUNT = 8;
	localparam int LED_IDX_W = $clog2(LED_COUNT);
	localparam logic [LED_IDX_W-1:0] LED_IDX_LAST = LED_IDX_W'(LED_COUNT - 1);

	// Field widths.
	localparam int RPM_W     = 14;
	localparam int MS_W      = 16;
	localparam int COLOR_W   = 24;
	localparam int CH_W      = 8;
	localparam int PAIRS_W   = 3;
	localparam int CFG_IDX_W = 3;

	// Pair counts and channel limits.
	localparam logic [PAIRS_W-1:0] PAIRS_FULL  = 3'd4;
	localparam logic [PAIRS_W-1:0] PAIRS_STALL = 3'd2;
	localparam logic [CH_W-1:0]    CH_MAX      = 8'hFF;

	// Shared divider: 22-bit dividend, 14-bit divisor, one quotient bit a cycle.
	localparam int DIV_NUM_W = 22;
	localparam int DIV_DEN_W = 14;
	localparam int DIV_STEPS = DIV_NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Register reset values.
	localparam logic [RPM_W-1:0]   RST_STALL_RPM   = 14'd500;
	localparam logic [RPM_W-1:0]   RST_LOW_RPM     = 14'd3000;
	localparam logic [RPM_W-1:0]   RST_MID_RPM     = 14'd5000;
	localparam logic [RPM_W-1:0]   RST_HIGH_RPM    = 14'd6500;
	localparam logic [COLOR_W-1:0] RST_MID_COLOR   = 24'h00FF00;
	localparam logic [COLOR_W-1:0] RST_OVER_COLOR  = 24'hFF0000;
	localparam logic [COLOR_W-1:0] RST_STALL_COLOR = 24'h0000FF;
	localparam logic [MS_W-1:0]    RST_BLINK_MS    = 16'd50;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STALL_RPM,
		CFG_LOW_RPM,
		CFG_MID_RPM,
		CFG_HIGH_RPM,
		CFG_MID_COLOR,
		CFG_OVER_COLOR,
		CFG_STALL_COLOR,
		CFG_BLINK_MS
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAIRS,
		ST_GRAD,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	// Divider status towards the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/core/rpm_shift_light_bar.sv */
// ----------------------------------------------------------------------------
// rpm_shift_light_bar
// Eight-LED shift light: pair count and band colour from engine rpm, with an
// overrev blink and change detection.
// ----------------------------------------------------------------------------
// Each display update is handled on its own: the block stalls its input until
// the update is finished. A shared restoring divider first computes the pair
// count and, in the gradient band only, then the red level; the block then
// decides whether the bar changed and, if so, emits eight LED items, which
// the output may stall.
// Configuration registers may be written only while no update is in work.
module rpm_shift_light_bar (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port
	input  logic                              cfg_we,
	input  logic [rpmslb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpmslb_pkg::COLOR_W-1:0]    cfg_wdata,
	// Display update channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rpmslb_pkg::RPM_W-1:0]      engine_rpm,
	input  logic [rpmslb_pkg::MS_W-1:0]       elapsed_ms,
	// LED item channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rpmslb_pkg::LED_IDX_W-1:0]  led_index,
	output logic [rpmslb_pkg::CH_W-1:0]       red,
	output logic [rpmslb_pkg::CH_W-1:0]       green,
	output logic [rpmslb_pkg::CH_W-1:0]       blue,
	output logic                              last_led
);
	import rpmslb_pkg::*;

	// Configuration registers.
	logic [RPM_W-1:0]   stall_rpm_q, low_rpm_q, mid_rpm_q, high_rpm_q;
	logic [COLOR_W-1:0] mid_color_q, over_color_q, stall_color_q;
	logic [MS_W-1:0]    blink_ms_q;

	// Sequencer and item state.
	state_t             state_q, state_d;
	logic [RPM_W-1:0]   rpm_q;
	logic [MS_W-1:0]    elapsed_q;
	logic [PAIRS_W-1:0] pairs_raw_q;
	logic [CH_W-1:0]    t_q;
	logic               prev_valid_q;
	logic [PAIRS_W-1:0] prev_pairs_q;
	logic [COLOR_W-1:0] prev_color_q;
	logic               blink_phase_q;
	logic [LED_IDX_W-1:0] led_cnt_q;
	logic [PAIRS_W-1:0] emit_pairs_q;
	logic [COLOR_W-1:0] emit_color_q;
	logic               emit_stalled_q;

	// Divider connections.
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_NUM_W-1:0] div_quot;
	div_stat_t            div_stat;

	// Band decode and decision logic.
	logic               stalled, below_low, below_mid, overrev, grad_band;
	logic               blink_hit, phase_n, changed;
	logic [RPM_W-1:0]   grad_diff;
	logic [PAIRS_W-1:0] pairs_clamped, final_pairs;
	logic [CH_W-1:0]    t_clamped;
	logic [COLOR_W-1:0] grad_color, final_color;
	logic               in_acc, out_acc;

	// LED emission.
	logic [LED_IDX_W-1:0] mirror, near;
	logic [PAIRS_W-1:0]   level;
	logic [COLOR_W-1:0]   led_color;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_rpm_q   <= RST_STALL_RPM;
			low_rpm_q     <= RST_LOW_RPM;
			mid_rpm_q     <= RST_MID_RPM;
			high_rpm_q    <= RST_HIGH_RPM;
			mid_color_q   <= RST_MID_COLOR;
			over_color_q  <= RST_OVER_COLOR;
			stall_color_q <= RST_STALL_COLOR;
			blink_ms_q    <= RST_BLINK_MS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_STALL_RPM:   stall_rpm_q   <= cfg_wdata[RPM_W-1:0];
				CFG_LOW_RPM:     low_rpm_q     <= cfg_wdata[RPM_W-1:0];
				CFG_MID_RPM:     mid_rpm_q     <= cfg_wdata[RPM_W-1:0];
				CFG_HIGH_RPM:    high_rpm_q    <= cfg_wdata[RPM_W-1:0];
				CFG_MID_COLOR:   mid_color_q   <= cfg_wdata;
				CFG_OVER_COLOR:  over_color_q  <= cfg_wdata;
				CFG_STALL_COLOR: stall_color_q <= cfg_wdata;
				CFG_BLINK_MS:    blink_ms_q    <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Band decode of the held rpm.
	assign stalled   = rpm_q < stall_rpm_q;
	assign below_low = rpm_q < low_rpm_q;
	assign below_mid = rpm_q < mid_rpm_q;
	assign overrev   = !stalled && !below_low && !below_mid && (rpm_q > high_rpm_q);
	assign grad_band = !stalled && !below_low && !below_mid && !overrev;

	// Divider operands: pair count at accept, gradient afterwards.
	assign grad_diff = rpm_q - mid_rpm_q;
	always_comb begin
		if (state_q == ST_IDLE) begin
			div_num = DIV_NUM_W'({engine_rpm, 2'b00});
			div_den = high_rpm_q;
		end else begin
			div_num = DIV_NUM_W'({grad_diff, 8'h00}) - DIV_NUM_W'(grad_diff);
			div_den = high_rpm_q - mid_rpm_q;
		end
	end

	// Quotient clamps; a zero divisor gives all ones and so the full value.
	assign pairs_clamped = ((div_quot[DIV_NUM_W-1:PAIRS_W] != '0) ||
		(div_quot[PAIRS_W-1:0] > PAIRS_FULL)) ? PAIRS_FULL : div_quot[PAIRS_W-1:0];
	assign t_clamped = (div_quot[DIV_NUM_W-1:CH_W] != '0) ? CH_MAX : div_quot[CH_W-1:0];

	// Final pair count and colour for this update.
	assign blink_hit  = elapsed_q >= blink_ms_q;
	assign phase_n    = !blink_phase_q;
	assign grad_color = {t_q, CH_MAX - t_q, {CH_W{1'b0}}};
	always_comb begin
		final_pairs = pairs_raw_q;
		final_color = '0;
		if (stalled) begin
			final_pairs = PAIRS_STALL;
		end else if (below_low) begin
			final_color = '0;
		end else if (below_mid) begin
			final_color = mid_color_q;
		end else if (!overrev) begin
			final_color = grad_color;
		end else begin
			final_pairs = PAIRS_FULL;
			final_color = (blink_hit && phase_n) ? over_color_q : '0;
		end
	end
	assign changed = !prev_valid_q || (final_pairs != prev_pairs_q) ||
		(final_color != prev_color_q);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and strobes.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					div_start = 1'b1;
					state_d   = ST_PAIRS;
				end
			end
			ST_PAIRS: begin
				if (div_stat.done) begin
					if (grad_band) begin
						div_start = 1'b1;
						state_d   = ST_GRAD;
					end else begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_GRAD: begin
				if (div_stat.done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = changed ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall && (led_cnt_q == LED_IDX_LAST)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// History, blink phase and LED counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q  <= 1'b0;
			prev_pairs_q  <= '0;
			prev_color_q  <= '0;
			blink_phase_q <= 1'b0;
			led_cnt_q     <= '0;
		end else begin
			if (state_q == ST_DECIDE) begin
				if (overrev && blink_hit) begin
					blink_phase_q <= phase_n;
				end
				if (changed) begin
					prev_valid_q <= 1'b1;
					prev_pairs_q <= final_pairs;
					prev_color_q <= final_color;
					led_cnt_q    <= '0;
				end
			end else if (out_acc) begin
				led_cnt_q <= led_cnt_q + 1'b1;
			end
		end
	end

	// Item payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rpm_q     <= engine_rpm;
			elapsed_q <= elapsed_ms;
		end
		if ((state_q == ST_PAIRS) && div_stat.done) begin
			pairs_raw_q <= pairs_clamped;
		end
		if ((state_q == ST_GRAD) && div_stat.done) begin
			t_q <= t_clamped;
		end
		if ((state_q == ST_DECIDE) && changed) begin
			emit_pairs_q   <= final_pairs;
			emit_color_q   <= final_color;
			emit_stalled_q <= stalled;
		end
	end

	// Shared divider.
	rpmslb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	// LED colour: pairs light from the outside in, stall colour in the centre.
	assign mirror = LED_IDX_LAST - led_cnt_q;
	assign near   = (led_cnt_q < mirror) ? led_cnt_q : mirror;
	assign level  = PAIRS_W'(near) + 1'b1;
	always_comb begin
		led_color = (emit_pairs_q >= level) ? emit_color_q : '0;
		if (emit_stalled_q && (level == PAIRS_FULL)) begin
			led_color = stall_color_q;
		end
	end

	assign led_index = led_cnt_q;
	assign red       = led_color[COLOR_W-1 -: CH_W];
	assign green     = led_color[2*CH_W-1 -: CH_W];
	assign blue      = led_color[CH_W-1:0];
	assign last_led  = (led_cnt_q == LED_IDX_LAST);

	// Checks on the sequencing.
	a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while LED items are pending");

	a_last_led_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_led) |-> (led_index == LED_IDX_LAST))
		else $error("last LED flag on a wrong position");

	a_idle_after_bar: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_led) |=> (!out_valid && !in_stall))
		else $error("block not idle after the eighth LED item");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

endmodule

/* rtl/core/rpmslb_div.sv */
// ----------------------------------------------------------------------------
// rpmslb_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// pair count and the colour gradient. A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module rpmslb_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rpmslb_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [rpmslb_pkg::DIV_DEN_W-1:0] divisor,
	output logic [rpmslb_pkg::DIV_NUM_W-1:0] quotient,
	output rpmslb_pkg::div_stat_t           stat
);
	import rpmslb_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	// One trial subtraction per cycle.
	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	// Control: step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out at the top, quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign quotient  = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
